/* sv/bdq_pkg.sv */
package bdq_pkg;

  // Store geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int MODE_BITS = 3;
  localparam int STAT_BITS = 2;

  localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(DEPTH);
  localparam logic [ADDR_BITS:0]   SUM_DEPTH = (ADDR_BITS + 1)'(DEPTH);
  localparam logic [ADDR_BITS-1:0] SLOT_LAST = ADDR_BITS'(DEPTH - 1);

  // Operation codes
  localparam logic [MODE_BITS-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_ERASE      = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_COUNT      = 3'd5;

  // Status codes
  localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_OVERFLOW  = 2'd2;

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_READ,
    CMD_POP_TAKE,
    CMD_SCAN,
    CMD_SCAN_END,
    CMD_READ_FRONT,
    CMD_READ_BACK,
    CMD_TAKE_BACK
  } dp_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 err;
    logic                 scan_done;
  } dp_stat_t;

  // Physical slot of logical position pos counted from base (pos < DEPTH)
  function automatic logic [ADDR_BITS-1:0] slot_of(input logic [ADDR_BITS-1:0] base,
                                                   input logic [CNT_BITS-1:0] pos);
    logic [ADDR_BITS:0] sum;
    sum = {1'b0, base} + {1'b0, pos[ADDR_BITS-1:0]};
    if (sum >= SUM_DEPTH) sum = sum - SUM_DEPTH;
    return sum[ADDR_BITS-1:0];
  endfunction

endpackage

/* sv/bdq_ram.sv */
module bdq_ram #(
  parameter int WIDTH       = 32,
  parameter int DEPTH_WORDS = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH_WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH_WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH_WORDS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/bdq_ctrl.sv */
module bdq_ctrl import bdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN,
    S_FRONT,
    S_BACK,
    S_TAKE,
    S_OUT
  } state_t;

  state_t state, state_next;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd        = CMD_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FRONT;
        if (!stat.err) begin
          case (stat.mode)
            MODE_PUSH_FRONT: cmd = CMD_PUSH_FRONT;
            MODE_PUSH_BACK:  cmd = CMD_PUSH_BACK;
            MODE_POP_FRONT, MODE_POP_BACK: begin
              cmd        = CMD_POP_READ;
              state_next = S_POP_WAIT;
            end
            MODE_ERASE, MODE_COUNT: state_next = S_SCAN;
            default: cmd = CMD_NONE;
          endcase
        end
      end
      S_POP_WAIT: begin
        cmd        = CMD_POP_TAKE;
        state_next = S_FRONT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd        = CMD_SCAN_END;
          state_next = S_FRONT;
        end else begin
          cmd = CMD_SCAN;
        end
      end
      S_FRONT: begin
        cmd        = CMD_READ_FRONT;
        state_next = S_BACK;
      end
      S_BACK: begin
        cmd        = CMD_READ_BACK;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd        = CMD_TAKE_BACK;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_stall  <= (state_next != S_IDLE);
      out_valid <= (state_next == S_OUT);
    end
  end

endmodule

/* sv/bdq_dp.sv */
module bdq_dp import bdq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [WORD_BITS-1:0] value,
  output dp_stat_t             stat,
  output logic [WORD_BITS-1:0] popped_word,
  output logic [CNT_BITS-1:0]  match_total,
  output logic [CNT_BITS-1:0]  occupancy,
  output logic [WORD_BITS-1:0] front_word,
  output logic [WORD_BITS-1:0] back_word,
  output logic [STAT_BITS-1:0] status
);

  logic [MODE_BITS-1:0] op_mode;
  logic [WORD_BITS-1:0] op_value;
  logic [ADDR_BITS-1:0] head;
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  rd_idx;
  logic [CNT_BITS-1:0]  kept;
  logic                 pend;
  logic                 err;

  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [ADDR_BITS-1:0] raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata;

  logic                 full, empty, is_match, is_push, is_take;
  logic [ADDR_BITS-1:0] head_dec, head_inc;
  logic [CNT_BITS-1:0]  last_pos;
  logic [STAT_BITS-1:0] load_status;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign head_dec = (head == '0) ? SLOT_LAST : head - ADDR_BITS'(1);
  assign head_inc = (head == SLOT_LAST) ? '0 : head + ADDR_BITS'(1);
  assign last_pos = count - CNT_BITS'(1);
  assign is_match = (rdata == op_value);
  assign is_push  = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK);
  assign is_take  = (mode == MODE_POP_FRONT) || (mode == MODE_POP_BACK) ||
                    (mode == MODE_ERASE);

  // Status of a new operation, from the occupancy before it
  always_comb begin
    if (is_push && full)       load_status = STAT_OVERFLOW;
    else if (is_take && empty) load_status = STAT_UNDERFLOW;
    else                       load_status = STAT_OK;
  end

  // Store addressing
  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = op_value;
    raddr = head;
    case (cmd)
      CMD_PUSH_FRONT: begin
        we    = 1'b1;
        waddr = head_dec;
      end
      CMD_PUSH_BACK: begin
        we    = 1'b1;
        waddr = slot_of(head, count);
      end
      CMD_POP_READ: begin
        if (op_mode == MODE_POP_BACK) raddr = slot_of(head, last_pos);
      end
      CMD_SCAN: begin
        raddr = slot_of(head, rd_idx);
        // compact survivors toward the front during an erase
        if (pend && !is_match && op_mode == MODE_ERASE) begin
          we    = 1'b1;
          waddr = slot_of(head, kept);
          wdata = rdata;
        end
      end
      CMD_READ_BACK: raddr = slot_of(head, last_pos);
      default: raddr = head;
    endcase
  end

  bdq_ram #(
    .WIDTH       (WORD_BITS),
    .DEPTH_WORDS (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Queue pointers and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      rd_idx <= '0;
      kept   <= '0;
      pend   <= 1'b0;
      err    <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          rd_idx <= '0;
          kept   <= '0;
          pend   <= 1'b0;
          err    <= (load_status != STAT_OK);
        end
        CMD_PUSH_FRONT: begin
          head  <= head_dec;
          count <= count + CNT_BITS'(1);
        end
        CMD_PUSH_BACK: count <= count + CNT_BITS'(1);
        CMD_POP_TAKE: begin
          if (op_mode == MODE_POP_FRONT) head <= head_inc;
          count <= last_pos;
        end
        CMD_SCAN: begin
          if (rd_idx != count) rd_idx <= rd_idx + CNT_BITS'(1);
          pend <= (rd_idx != count);
          if (pend && !is_match) kept <= kept + CNT_BITS'(1);
        end
        CMD_SCAN_END: begin
          if (op_mode == MODE_ERASE) count <= kept;
        end
        default: count <= count;
      endcase
    end
  end

  // Operation latch and result registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_mode     <= mode;
        op_value    <= value;
        popped_word <= '0;
        match_total <= '0;
        status      <= load_status;
      end
      CMD_POP_TAKE: popped_word <= rdata;
      CMD_SCAN: begin
        if (pend && is_match) match_total <= match_total + CNT_BITS'(1);
      end
      CMD_READ_BACK: front_word <= empty ? '0 : rdata;
      CMD_TAKE_BACK: back_word  <= empty ? '0 : rdata;
      default: status <= status;
    endcase
  end

  assign occupancy      = count;
  assign stat.mode      = op_mode;
  assign stat.err       = err;
  assign stat.scan_done = (rd_idx == count) && !pend;

endmodule

/* sv/bounded_deque_with_erase.sv */
// Bounded double-ended queue of 32-bit words with erase-by-value and count.
// Input channel: in_valid / in_stall carries mode and value; a transfer
// happens at a clock edge with in_valid high and in_stall low. Output
// channel: out_valid / out_stall carries one result per input item.
// Modes: push front, push back, pop front, pop back, erase value, count.
// One item is in flight at a time; in_stall is high from the transfer until
// its result has been taken.
// After an input transfer the controller passes through S_EXEC, S_FRONT,
// S_BACK and S_TAKE to S_OUT. Pops add S_POP_WAIT after S_EXEC; erase and
// count add S_SCAN, which reads every occupied entry. Rejected operations
// (overflow, underflow) and unused modes take the shortest path.
// The scan
// reads the store one entry per cycle through its single read port; front
// and back words are re-read from the store after every operation.
// A result waits in the output registers while out_stall is high; the next
// item is taken the cycle after the result transfers.
// Reset (rst, synchronous) empties the queue; store contents are not
// cleared; data read from outside the occupied range is never used.
module bounded_deque_with_erase import bdq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [WORD_BITS-1:0] value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] popped_word,
  output logic [CNT_BITS-1:0]  match_total,
  output logic [CNT_BITS-1:0]  occupancy,
  output logic [WORD_BITS-1:0] front_word,
  output logic [WORD_BITS-1:0] back_word,
  output logic [STAT_BITS-1:0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .value       (value),
    .stat        (stat),
    .popped_word (popped_word),
    .match_total (match_total),
    .occupancy   (occupancy),
    .front_word  (front_word),
    .back_word   (back_word),
    .status      (status)
  );

endmodule

/* sv/bdq_checker.sv */
module bdq_checker import bdq_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [MODE_BITS-1:0] mode,
  input logic [WORD_BITS-1:0] value,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_BITS-1:0] popped_word,
  input logic [CNT_BITS-1:0]  match_total,
  input logic [CNT_BITS-1:0]  occupancy,
  input logic [WORD_BITS-1:0] front_word,
  input logic [WORD_BITS-1:0] back_word,
  input logic [STAT_BITS-1:0] status
);

  // One item in flight: input closes right after a transfer
  a_in_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transfer");

  // One result per item
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

  // Occupancy never exceeds the store
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= CNT_FULL))
    else $error("occupancy out of range");

  // Empty queue reports zero ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && occupancy == '0) |-> (front_word == '0 && back_word == '0))
    else $error("nonzero ends on empty queue");

  // Overflow only when full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_OVERFLOW) |-> (occupancy == CNT_FULL))
    else $error("overflow while not full");

endmodule

bind bounded_deque_with_erase bdq_checker u_bdq_checker (.*);
